### design/cqgu_pkg.sv
`default_nettype none

package cqgu_pkg;

    // Field widths.
    localparam int DATA_W  = 32;
    localparam int ROW_W   = 10;
    localparam int COL_W   = 10;
    localparam int TB_W    = 4;
    localparam int CB_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2 * DATA_W;

    // Datapath widths: full product, pair sum, four-term sum, after the shift.
    localparam int FRAC_W  = DATA_W - 2;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int PAIR_W  = PROD_W + 1;
    localparam int SUM_W   = PROD_W + 2;
    localparam int SHIFT_W = SUM_W - FRAC_W;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_U00       = 3'd0,
        CFG_U01       = 3'd1,
        CFG_U10       = 3'd2,
        CFG_U11       = 3'd3,
        CFG_TARGET    = 3'd4,
        CFG_CONTROL   = 3'd5,
        CFG_ZERO_MODE = 3'd6
    } cfg_idx_t;

    // Result action codes.
    typedef enum logic [1:0] {
        ACT_TRANSFORM = 2'd0,
        ACT_ZERO      = 2'd1,
        ACT_PASS      = 2'd2
    } action_t;

    // One complex value; real part sits in the upper half.
    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } cplx_t;

    // Register file contents.
    typedef struct packed {
        cplx_t                  u00;
        cplx_t                  u01;
        cplx_t                  u10;
        cplx_t                  u11;
        logic [TB_W-1:0]        target_bit;
        logic signed [CB_W-1:0] control_bit;
        logic                   zero_mode;
    } cfg_t;

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    // Saturated component and its clip flag.
    typedef struct packed {
        logic                     clip;
        logic signed [DATA_W-1:0] val;
    } sat_res_t;

    localparam cplx_t UNIT_ONE = '{re: 32'sh4000_0000, im: 32'sh0000_0000};

    // Clip a shifted sum to the signed data range.
    function automatic sat_res_t saturate(input logic signed [SHIFT_W-1:0] v);
        logic signed [SHIFT_W-1:0] max_v;
        logic signed [SHIFT_W-1:0] min_v;
        sat_res_t                  r;
        max_v = {{(SHIFT_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        min_v = {{(SHIFT_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        if (v > max_v) begin
            r.clip = 1'b1;
            r.val  = max_v[DATA_W-1:0];
        end else if (v < min_v) begin
            r.clip = 1'b1;
            r.val  = min_v[DATA_W-1:0];
        end else begin
            r.clip = 1'b0;
            r.val  = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/cqgu_cfg.sv
`default_nettype none

module cqgu_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cqgu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cqgu_pkg::CFG_DATA_W-1:0]  cfg_data,
    output cqgu_pkg::cfg_t                        cfg
);

    cqgu_pkg::cfg_t cfg_reg;
    cqgu_pkg::cfg_t cfg_next;

    // Writes always complete in the cycle they are offered.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index; indexes past the list are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cqgu_pkg::cfg_idx_t'(cfg_index))
                cqgu_pkg::CFG_U00:       cfg_next.u00 = cfg_data;
                cqgu_pkg::CFG_U01:       cfg_next.u01 = cfg_data;
                cqgu_pkg::CFG_U10:       cfg_next.u10 = cfg_data;
                cqgu_pkg::CFG_U11:       cfg_next.u11 = cfg_data;
                cqgu_pkg::CFG_TARGET:
                    cfg_next.target_bit = cfg_data[cqgu_pkg::TB_W-1:0];
                cqgu_pkg::CFG_CONTROL:
                    cfg_next.control_bit = cfg_data[cqgu_pkg::CB_W-1:0];
                cqgu_pkg::CFG_ZERO_MODE: cfg_next.zero_mode = cfg_data[0];
                default: ;
            endcase
        end
    end

    // Identity matrix, no control, pass mode after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.u00         <= cqgu_pkg::UNIT_ONE;
            cfg_reg.u01         <= '0;
            cfg_reg.u10         <= '0;
            cfg_reg.u11         <= cqgu_pkg::UNIT_ONE;
            cfg_reg.target_bit  <= '0;
            cfg_reg.control_bit <= '1;
            cfg_reg.zero_mode   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### design/cqgu_cmac.sv
`default_nettype none

// One complex result a*x + b*y over four stages: multiply, pair add,
// final add, shift and saturate with the action select.
module cqgu_cmac (
    input  wire logic                clk,
    input  wire cqgu_pkg::stage_en_t en,
    input  wire cqgu_pkg::cplx_t     coef_a,
    input  wire cqgu_pkg::cplx_t     coef_b,
    input  wire cqgu_pkg::cplx_t     elem_x,
    input  wire cqgu_pkg::cplx_t     elem_y,
    input  wire cqgu_pkg::cplx_t     pass_val,
    input  wire cqgu_pkg::action_t   action,
    output cqgu_pkg::cplx_t          result,
    output logic                     sat
);

    localparam int PW = cqgu_pkg::PROD_W;
    localparam int AW = cqgu_pkg::PAIR_W;
    localparam int SW = cqgu_pkg::SUM_W;
    localparam int HW = cqgu_pkg::SHIFT_W;

    // Stage 1: eight products.
    logic signed [PW-1:0] p_axr_reg, p_axi_reg, p_byr_reg, p_byi_reg;
    logic signed [PW-1:0] q_axi_reg, q_axr_reg, q_byi_reg, q_byr_reg;
    cqgu_pkg::cplx_t      pass1_reg;
    // Stage 2: pair sums.
    logic signed [AW-1:0] re_a_reg, re_b_reg, im_a_reg, im_b_reg;
    cqgu_pkg::cplx_t      pass2_reg;
    // Stage 3: full sums.
    logic signed [SW-1:0] re_sum_reg, im_sum_reg;
    cqgu_pkg::cplx_t      pass3_reg;
    // Stage 4: output.
    cqgu_pkg::cplx_t      result_reg, result_next;
    logic                 sat_reg, sat_next;

    logic signed [HW-1:0]   re_shift, im_shift;
    cqgu_pkg::sat_res_t     re_sat, im_sat;

    // Multiply: real parts pair re*re and im*im, imaginary parts cross.
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            p_axr_reg <= coef_a.re * elem_x.re;
            p_axi_reg <= coef_a.im * elem_x.im;
            p_byr_reg <= coef_b.re * elem_y.re;
            p_byi_reg <= coef_b.im * elem_y.im;
            q_axi_reg <= coef_a.re * elem_x.im;
            q_axr_reg <= coef_a.im * elem_x.re;
            q_byi_reg <= coef_b.re * elem_y.im;
            q_byr_reg <= coef_b.im * elem_y.re;
            pass1_reg <= pass_val;
        end
    end

    // Pair sums; the im*im terms enter with a minus sign.
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            re_a_reg  <= AW'(p_axr_reg) - AW'(p_axi_reg);
            re_b_reg  <= AW'(p_byr_reg) - AW'(p_byi_reg);
            im_a_reg  <= AW'(q_axi_reg) + AW'(q_axr_reg);
            im_b_reg  <= AW'(q_byi_reg) + AW'(q_byr_reg);
            pass2_reg <= pass1_reg;
        end
    end

    // Four-term sums, exact.
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            re_sum_reg <= SW'(re_a_reg) + SW'(re_b_reg);
            im_sum_reg <= SW'(im_a_reg) + SW'(im_b_reg);
            pass3_reg  <= pass2_reg;
        end
    end

    // Floor shift by the fraction width, then clip.
    assign re_shift = HW'(re_sum_reg >>> cqgu_pkg::FRAC_W);
    assign im_shift = HW'(im_sum_reg >>> cqgu_pkg::FRAC_W);
    assign re_sat   = cqgu_pkg::saturate(re_shift);
    assign im_sat   = cqgu_pkg::saturate(im_shift);

    // Pick the transformed, zeroed or untouched pair.
    always_comb
    begin
        unique case (action)
            cqgu_pkg::ACT_TRANSFORM:
            begin
                result_next.re = re_sat.val;
                result_next.im = im_sat.val;
                sat_next       = re_sat.clip | im_sat.clip;
            end
            cqgu_pkg::ACT_ZERO:
            begin
                result_next = '0;
                sat_next    = 1'b0;
            end
            default:
            begin
                result_next = pass3_reg;
                sat_next    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign result = result_reg;
    assign sat    = sat_reg;

endmodule

`default_nettype wire

### design/controlled_qubit_gate_pair_update_top.sv
`default_nettype none

// Channel   Handshake                 Payload
// -------   ---------                 -------
// input     in_valid / in_ready       lower_row, column_index, first_*, second_*
// result    out_valid / out_ready     partner_row, column_out, new_*, action_taken,
//                                     saturated
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One element pair per cycle unless a stalled result backs up the pipe. Pipeline stages:
// multiply, pair add, final add, shift and saturate into the output register.
// Stage one holds sixteen 32x32 multipliers, one per product, so no stage iterates.
// Reset clears the stage valid bits and loads the identity matrix with no control.
// A stalled result holds the output stage; the stage enables chain back from
// out_ready to in_ready within the cycle, so a bubble in the pipe is filled while
// the output waits. Config writes are never stalled and act on pairs transferred
// after them.
module controlled_qubit_gate_pair_update_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Input pairs.
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [cqgu_pkg::ROW_W-1:0]           lower_row,
    input  wire logic [cqgu_pkg::COL_W-1:0]           column_index,
    input  wire logic signed [cqgu_pkg::DATA_W-1:0]   first_re,
    input  wire logic signed [cqgu_pkg::DATA_W-1:0]   first_im,
    input  wire logic signed [cqgu_pkg::DATA_W-1:0]   second_re,
    input  wire logic signed [cqgu_pkg::DATA_W-1:0]   second_im,
    // Results.
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [cqgu_pkg::ROW_W-1:0]                partner_row,
    output logic [cqgu_pkg::COL_W-1:0]                column_out,
    output logic signed [cqgu_pkg::DATA_W-1:0]        new_first_re,
    output logic signed [cqgu_pkg::DATA_W-1:0]        new_first_im,
    output logic signed [cqgu_pkg::DATA_W-1:0]        new_second_re,
    output logic signed [cqgu_pkg::DATA_W-1:0]        new_second_im,
    output logic [1:0]                                action_taken,
    output logic                                      saturated,
    // Configuration writes.
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [cqgu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [cqgu_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int RW = cqgu_pkg::ROW_W;
    localparam int CW = cqgu_pkg::COL_W;

    cqgu_pkg::cfg_t      cfg;
    cqgu_pkg::stage_en_t en;
    cqgu_pkg::cplx_t     elem_x, elem_y;
    cqgu_pkg::cplx_t     res_first, res_second;
    logic                sat_first, sat_second;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [RW-1:0] row1_reg, row2_reg, row3_reg, row4_reg;
    logic [CW-1:0] col1_reg, col2_reg, col3_reg, col4_reg;
    cqgu_pkg::action_t act1_reg, act2_reg, act3_reg, act4_reg;
    cqgu_pkg::action_t act1_next;
    logic [RW-1:0]     row1_next;
    logic [RW-1:0]     ctl_shift;

    cqgu_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A stage loads when it is empty or its content moves on.
    assign en.s4    = !s4_valid_reg || out_ready;
    assign en.s3    = !s3_valid_reg || en.s4;
    assign en.s2    = !s2_valid_reg || en.s3;
    assign en.s1    = !s1_valid_reg || en.s2;
    assign in_ready = en.s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en.s1) s1_valid_reg <= in_valid;
            if (en.s2) s2_valid_reg <= s1_valid_reg;
            if (en.s3) s3_valid_reg <= s2_valid_reg;
            if (en.s4) s4_valid_reg <= s3_valid_reg;
        end
    end

    // Control test and partner row; offsets past the row width wrap to zero.
    assign ctl_shift = lower_row >> cfg.control_bit[cqgu_pkg::CB_W-2:0];
    assign row1_next = lower_row + (RW'(1) << cfg.target_bit);

    always_comb
    begin
        priority if (cfg.control_bit[cqgu_pkg::CB_W-1] || ctl_shift[0])
            act1_next = cqgu_pkg::ACT_TRANSFORM;
        else if (cfg.zero_mode)
            act1_next = cqgu_pkg::ACT_ZERO;
        else
            act1_next = cqgu_pkg::ACT_PASS;
    end

    // Side fields travel with the pair.
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            row1_reg <= row1_next;
            col1_reg <= column_index;
            act1_reg <= act1_next;
        end
        if (en.s2)
        begin
            row2_reg <= row1_reg;
            col2_reg <= col1_reg;
            act2_reg <= act1_reg;
        end
        if (en.s3)
        begin
            row3_reg <= row2_reg;
            col3_reg <= col2_reg;
            act3_reg <= act2_reg;
        end
        if (en.s4)
        begin
            row4_reg <= row3_reg;
            col4_reg <= col3_reg;
            act4_reg <= act3_reg;
        end
    end

    assign elem_x.re = first_re;
    assign elem_x.im = first_im;
    assign elem_y.re = second_re;
    assign elem_y.im = second_im;

    // Lower row: u00*x + u01*y.
    cqgu_cmac u_cmac_first (
        .clk      (clk),
        .en       (en),
        .coef_a   (cfg.u00),
        .coef_b   (cfg.u01),
        .elem_x   (elem_x),
        .elem_y   (elem_y),
        .pass_val (elem_x),
        .action   (act3_reg),
        .result   (res_first),
        .sat      (sat_first)
    );

    // Partner row: u10*x + u11*y.
    cqgu_cmac u_cmac_second (
        .clk      (clk),
        .en       (en),
        .coef_a   (cfg.u10),
        .coef_b   (cfg.u11),
        .elem_x   (elem_x),
        .elem_y   (elem_y),
        .pass_val (elem_y),
        .action   (act3_reg),
        .result   (res_second),
        .sat      (sat_second)
    );

    assign out_valid     = s4_valid_reg;
    assign partner_row   = row4_reg;
    assign column_out    = col4_reg;
    assign new_first_re  = res_first.re;
    assign new_first_im  = res_first.im;
    assign new_second_re = res_second.re;
    assign new_second_im = res_second.im;
    assign action_taken  = act4_reg;
    assign saturated     = sat_first | sat_second;

    // Only a transformed pair can clip.
    a_sat_only_transform: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> action_taken == cqgu_pkg::ACT_TRANSFORM)
        else $error("saturation flagged on a pair that was not transformed");

    // A zeroed pair carries all-zero components.
    a_zero_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action_taken == cqgu_pkg::ACT_ZERO |->
            new_first_re == '0 && new_first_im == '0 &&
            new_second_re == '0 && new_second_im == '0)
        else $error("zeroed pair has nonzero components");

    // A held result is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg && !out_ready |-> !en.s4)
        else $error("output stage loaded while its result was stalled");

    // An accepted pair always lands in stage one.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted pair lost at pipeline entry");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;
    import cqgu_pkg::*;

    localparam int CLOCK_LIMIT  = 300000;
    localparam int SETTLE_TICKS = 8;
    localparam int TAIL_TICKS   = 16;
    localparam int HOLD_TICKS   = 400;

    localparam cfg_t GATE_RESET = '{
        u00: UNIT_ONE, u01: '0, u10: '0, u11: UNIT_ONE,
        target_bit: '0, control_bit: -5'sd1, zero_mode: 1'b0
    };

    typedef enum {STEP_PAIR, STEP_WRITE, STEP_SETTLE, STEP_PHASE, STEP_HOLD} step_kind_t;

    // One entry of the stimulus stream: a pair, a register write or a control step.
    typedef struct {
        step_kind_t  kind;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [31:0] xr;
        logic [31:0] xi;
        logic [31:0] yr;
        logic [31:0] yi;
        cfg_idx_t    idx;
        logic [63:0] data;
        int          idle;
        int          stall;
    } stim_step_t;

    // Predicted contents of one result transfer.
    typedef struct {
        logic [9:0]  partner;
        logic [9:0]  column;
        logic [31:0] f_re;
        logic [31:0] f_im;
        logic [31:0] s_re;
        logic [31:0] s_im;
        action_t     action;
        logic        sat;
    } pair_update_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [9:0]  lower_row = '0;
    logic [9:0]  column_index = '0;
    logic signed [31:0] first_re = '0;
    logic signed [31:0] first_im = '0;
    logic signed [31:0] second_re = '0;
    logic signed [31:0] second_im = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [9:0]  partner_row;
    logic [9:0]  column_out;
    logic signed [31:0] new_first_re;
    logic signed [31:0] new_first_im;
    logic signed [31:0] new_second_re;
    logic signed [31:0] new_second_im;
    logic [1:0]  action_taken;
    logic        saturated;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    stim_step_t   pair_stream[$];
    pair_update_t pending_updates[$];
    cfg_t         gate = GATE_RESET;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_len = 0;
    int           hold_left = 0;
    int           settle = 0;
    logic         draining = 1'b0;
    logic         all_sent = 1'b0;
    int           errors = 0;
    int           cycles = 0;

    controlled_qubit_gate_pair_update_top dut (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    // Full-precision signed product, wide enough for a four-term sum.
    function automatic logic signed [66:0] cmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [66:0] pa;
        logic signed [66:0] pb;
        pa = 67'(a);
        pb = 67'(b);
        return pa * pb;
    endfunction

    // Floor shift back to Q2.30 and clip; bit 32 flags a clip.
    function automatic logic [32:0] scale_clip(input logic signed [66:0] acc);
        logic signed [66:0] sh;
        sh = acc >>> 30;
        if (sh > 67'sd2147483647)
        begin
            return {1'b1, 32'h7FFF_FFFF};
        end
        if (sh < -67'sd2147483648)
        begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, sh[31:0]};
    endfunction

    // Expected result of one pair under the given register settings.
    function automatic pair_update_t predict_update(input cfg_t g, input logic [9:0] row,
                                                    input logic [9:0] col,
                                                    input logic signed [31:0] xr,
                                                    input logic signed [31:0] xi,
                                                    input logic signed [31:0] yr,
                                                    input logic signed [31:0] yi);
        pair_update_t       r;
        logic [15:0]        row_bits;
        logic [15:0]        offset;
        logic signed [66:0] acc;
        logic [32:0]        c;
        row_bits = {6'd0, row};
        offset = 16'd1 << g.target_bit;
        r.partner = row + offset[9:0];
        r.column = col;
        r.sat = 1'b0;
        if (g.control_bit[4] || row_bits[g.control_bit[3:0]])
        begin
            acc = cmul(g.u00.re, xr) - cmul(g.u00.im, xi)
                + cmul(g.u01.re, yr) - cmul(g.u01.im, yi);
            c = scale_clip(acc);
            r.f_re = c[31:0];
            r.sat |= c[32];
            acc = cmul(g.u00.re, xi) + cmul(g.u00.im, xr)
                + cmul(g.u01.re, yi) + cmul(g.u01.im, yr);
            c = scale_clip(acc);
            r.f_im = c[31:0];
            r.sat |= c[32];
            acc = cmul(g.u10.re, xr) - cmul(g.u10.im, xi)
                + cmul(g.u11.re, yr) - cmul(g.u11.im, yi);
            c = scale_clip(acc);
            r.s_re = c[31:0];
            r.sat |= c[32];
            acc = cmul(g.u10.re, xi) + cmul(g.u10.im, xr)
                + cmul(g.u11.re, yi) + cmul(g.u11.im, yr);
            c = scale_clip(acc);
            r.s_im = c[31:0];
            r.sat |= c[32];
            r.action = ACT_TRANSFORM;
        end
        else if (g.zero_mode)
        begin
            r.f_re = '0;
            r.f_im = '0;
            r.s_re = '0;
            r.s_im = '0;
            r.action = ACT_ZERO;
        end
        else
        begin
            r.f_re = xr;
            r.f_im = xi;
            r.s_re = yr;
            r.s_im = yi;
            r.action = ACT_PASS;
        end
        return r;
    endfunction

    // Mirror of a register write on the predictor side.
    function automatic void write_gate(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
        case (cfg_idx_t'(idx))
            CFG_U00:       gate.u00 = d;
            CFG_U01:       gate.u01 = d;
            CFG_U10:       gate.u10 = d;
            CFG_U11:       gate.u11 = d;
            CFG_TARGET:    gate.target_bit = d[3:0];
            CFG_CONTROL:   gate.control_bit = d[4:0];
            CFG_ZERO_MODE: gate.zero_mode = d[0];
            default:       ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void add_pair(input logic [9:0] row, input logic [9:0] col,
                                     input logic [31:0] xr, input logic [31:0] xi,
                                     input logic [31:0] yr, input logic [31:0] yi);
        stim_step_t st;
        st = '{kind: STEP_PAIR, row: row, col: col, xr: xr, xi: xi, yr: yr, yi: yi,
               idx: CFG_U00, data: '0, idle: 0, stall: 0};
        pair_stream.push_back(st);
    endfunction

    function automatic void add_step(input step_kind_t kind, input cfg_idx_t idx,
                                     input logic [63:0] d, input int idle, input int stall);
        stim_step_t st;
        st = '{kind: kind, row: '0, col: '0, xr: '0, xi: '0, yr: '0, yi: '0,
               idx: idx, data: d, idle: idle, stall: stall};
        pair_stream.push_back(st);
    endfunction

    function automatic void add_write(input cfg_idx_t idx, input logic [63:0] d);
        add_step(STEP_WRITE, idx, d, 0, 0);
    endfunction

    function automatic void add_settle();
        add_step(STEP_SETTLE, CFG_U00, '0, 0, 0);
    endfunction

    function automatic void add_phase(input int idle, input int stall);
        add_step(STEP_PHASE, CFG_U00, '0, idle, stall);
    endfunction

    // Random Q2.30 value: full range, scaled down, or an extreme.
    function automatic logic [31:0] rand_q30();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $signed($urandom) >>> $urandom_range(1, 12);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    default: v = 32'h4000_0000;
                endcase
            end
            default: v = $signed($urandom) >>> 2;
        endcase
        return v;
    endfunction

    // Matrix coefficient, mostly within plus or minus one.
    function automatic logic [31:0] rand_coef();
        logic [31:0] v;
        if ($urandom_range(0, 3) == 0)
        begin
            v = $urandom;
        end
        else
        begin
            v = $signed($urandom) >>> $urandom_range(1, 6);
        end
        return v;
    endfunction

    // Driver: feeds pairs and register writes from the stimulus stream.
    always @(posedge clk or negedge rst_n)
    begin : pair_driver
        stim_step_t st;
        logic       in_take;
        logic       cfg_take;
        logic       in_nxt;
        logic       cfg_nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cfg_valid <= 1'b0;
            gate = GATE_RESET;
            draining = 1'b0;
            settle = 0;
            all_sent = 1'b0;
        end
        else
        begin
            in_take = in_valid && in_ready;
            cfg_take = cfg_valid && cfg_ready;
            // Record each completed transfer before choosing the next step.
            if (in_take)
            begin
                pending_updates.push_back(predict_update(gate, lower_row, column_index,
                                                         first_re, first_im,
                                                         second_re, second_im));
            end
            if (cfg_take)
            begin
                write_gate(cfg_index, cfg_data);
            end
            in_nxt = in_valid && !in_take;
            cfg_nxt = cfg_valid && !cfg_take;
            if (!in_nxt && !cfg_nxt)
            begin
                if (settle > 0)
                begin
                    settle--;
                end
                else if (draining)
                begin
                    if (pending_updates.size() == 0)
                    begin
                        draining = 1'b0;
                        settle = SETTLE_TICKS;
                    end
                end
                else if (pair_stream.size() == 0)
                begin
                    all_sent = 1'b1;
                end
                else if (pair_stream[0].kind != STEP_PAIR ||
                         $urandom_range(0, 99) >= send_idle_pct)
                begin
                    st = pair_stream.pop_front();
                    case (st.kind)
                        STEP_PAIR:
                        begin
                            lower_row <= st.row;
                            column_index <= st.col;
                            first_re <= st.xr;
                            first_im <= st.xi;
                            second_re <= st.yr;
                            second_im <= st.yi;
                            in_nxt = 1'b1;
                        end
                        STEP_WRITE:
                        begin
                            cfg_index <= st.idx;
                            cfg_data <= st.data;
                            cfg_nxt = 1'b1;
                        end
                        STEP_SETTLE: draining = 1'b1;
                        STEP_PHASE:
                        begin
                            send_idle_pct = st.idle;
                            recv_stall_pct = st.stall;
                        end
                        default: hold_len = HOLD_TICKS;
                    endcase
                end
            end
            in_valid <= in_nxt;
            cfg_valid <= cfg_nxt;
        end
    end

    // Monitor: checks each result transfer and drives the receiver side.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        pair_update_t want;
        logic         rdy;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_updates.size() == 0)
                begin
                    $error("unexpected result transfer: partner_row %h column_out %h",
                           partner_row, column_out);
                    errors++;
                end
                else
                begin
                    want = pending_updates.pop_front();
                    check_field("partner_row", 32'(want.partner), 32'(partner_row));
                    check_field("column_out", 32'(want.column), 32'(column_out));
                    check_field("new_first_re", want.f_re, new_first_re);
                    check_field("new_first_im", want.f_im, new_first_im);
                    check_field("new_second_re", want.s_re, new_second_re);
                    check_field("new_second_im", want.s_im, new_second_im);
                    check_field("action_taken", 32'(want.action), 32'(action_taken));
                    check_field("saturated", 32'(want.sat), 32'(saturated));
                end
            end
            // A long hold-off lets the pipeline fill and back up into the input.
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (hold_len > 0)
            begin
                hold_left = hold_len;
                hold_len = 0;
                rdy = 1'b0;
            end
            else
            begin
                rdy = ($urandom_range(0, 99) >= recv_stall_pct);
            end
            out_ready <= rdy;
        end
    end

    initial
    begin
        int          phase_idle[4];
        int          phase_stall[4];
        logic [3:0]  tgt;
        logic [4:0]  ctl;
        logic [9:0]  row;
        int          seg;
        int          i;

        phase_idle = '{0, 68, 0, 8};
        phase_stall = '{0, 0, 68, 8};

        // Reset settings: identity matrix, no control.
        add_phase(0, 0);
        add_pair(10'd0, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0);
        add_pair(10'd1022, 10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_pair(10'd510, 10'd512, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000);
        // Lower row with its target bit set wraps the partner row.
        add_pair(10'd1023, 10'd1, 32'h1234_5678, 32'h9ABC_DEF0,
                 32'h0F0F_0F0F, 32'hF0F0_F0F0);

        // Extreme coefficients that clip, control on bit 3, zero mode.
        add_settle();
        add_write(CFG_U00, {32'h7FFF_FFFF, 32'h8000_0000});
        add_write(CFG_U01, {32'h8000_0000, 32'h8000_0000});
        add_write(CFG_U10, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
        add_write(CFG_U11, {32'h8000_0000, 32'h7FFF_FFFF});
        add_write(CFG_TARGET, 64'd9);
        add_write(CFG_CONTROL, 64'd3);
        add_write(CFG_ZERO_MODE, 64'd1);
        add_pair(10'd8, 10'd5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_pair(10'd8, 10'd6, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_pair(10'd0, 10'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_pair(10'd1023, 10'd1023, 32'h4000_0000, 32'hC000_0000, 32'h1, 32'hFFFF_FFFF);

        // Control bit beyond the row width passes everything; top target bit.
        add_settle();
        add_write(CFG_CONTROL, 64'd12);
        add_write(CFG_ZERO_MODE, 64'd0);
        add_write(CFG_TARGET, 64'd15);
        add_pair(10'd1023, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_pair(10'd0, 10'd3, 32'h1, 32'h2, 32'h3, 32'h4);

        // Most negative control value means no control.
        add_settle();
        add_write(CFG_CONTROL, 64'h10);
        add_write(CFG_TARGET, 64'd10);
        add_write(CFG_U00, {32'h4000_0000, 32'h0});
        add_write(CFG_U01, {32'hC000_0000, 32'h0});
        add_write(CFG_U10, {32'h0, 32'h4000_0000});
        add_write(CFG_U11, 64'h0);
        add_pair(10'd5, 10'd9, 32'h4000_0000, 32'h0, 32'h2000_0000, 32'h0);
        add_pair(10'd0, 10'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);

        // Control on the top row bit, then on bit 0.
        add_settle();
        add_write(CFG_CONTROL, 64'd9);
        add_write(CFG_TARGET, 64'd0);
        add_pair(10'd512, 10'd100, 32'h3000_0000, 32'hD000_0000, 32'h7000_0000, 32'h1);
        add_pair(10'd510, 10'd100, 32'h3000_0000, 32'hD000_0000, 32'h7000_0000, 32'h1);
        add_settle();
        add_write(CFG_CONTROL, 64'd0);
        add_pair(10'd1, 10'd2, 32'h2000_0000, 32'h2000_0000, 32'hE000_0000, 32'hE000_0000);
        add_pair(10'd2, 10'd2, 32'h2000_0000, 32'h2000_0000, 32'hE000_0000, 32'hE000_0000);

        // Random segments, each with fresh settings and its own idling pattern.
        for (seg = 0; seg < 10; seg++)
        begin
            add_settle();
            add_write(CFG_U00, {rand_coef(), rand_coef()});
            add_write(CFG_U01, {rand_coef(), rand_coef()});
            add_write(CFG_U10, {rand_coef(), rand_coef()});
            add_write(CFG_U11, {rand_coef(), rand_coef()});
            tgt = (seg == 7) ? 4'd15 : 4'($urandom_range(0, 9));
            ctl = 5'($urandom_range(0, 11) - 1);
            add_write(CFG_TARGET, {60'd0, tgt});
            add_write(CFG_CONTROL, {59'd0, ctl});
            add_write(CFG_ZERO_MODE, 64'($urandom_range(0, 1)));
            add_phase(phase_idle[seg % 4], phase_stall[seg % 4]);
            if (seg == 4)
            begin
                add_phase(0, 0);
                add_step(STEP_HOLD, CFG_U00, '0, 0, 0);
            end
            for (i = 0; i < 75; i++)
            begin
                // The sender pauses once until the pipeline has drained.
                if (seg == 5 && i == 37)
                begin
                    add_settle();
                end
                row = 10'($urandom_range(0, 1023));
                if (tgt < 4'd10 && $urandom_range(0, 3) != 0)
                begin
                    row[tgt] = 1'b0;
                end
                add_pair(row, 10'($urandom_range(0, 1023)),
                         rand_q30(), rand_q30(), rand_q30(), rand_q30());
            end
        end

        // Reset, then wait for every transfer to complete.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while (!(all_sent && pending_updates.size() == 0) && cycles < CLOCK_LIMIT)
        begin
            @(posedge clk);
        end
        if (cycles >= CLOCK_LIMIT)
        begin
            $display("Regression FAIL");
        end
        else
        begin
            repeat (TAIL_TICKS) @(posedge clk);
            if (errors == 0 && pending_updates.size() == 0)
            begin
                $display("Regression PASS");
            end
            else
            begin
                $display("Regression FAIL");
            end
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
design/cqgu_pkg.sv
design/cqgu_cfg.sv
design/cqgu_cmac.sv
design/controlled_qubit_gate_pair_update_top.sv
tb/sv/testbench.sv
